// ----- rtl/core/ssrch_pkg.sv -----
`timescale 1ns / 1ps

package ssrch_pkg;

    localparam int NEEDLE_BYTES = 15;
    localparam int LEN_W        = 4;
    localparam int OFFSET_BITS  = 16;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 2;
    localparam int HIGH_W       = 56;

    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LEN  = 2'd2;

    typedef logic [7:0] byte_t;

    // needle bytes and the clamped length, as the matcher sees them
    typedef struct packed {
        logic [NEEDLE_BYTES-1:0][7:0] needle;
        logic [LEN_W-1:0]             len;
    } needle_cfg_t;

endpackage

// ----- rtl/core/ssrch_cfg.sv -----
`timescale 1ns / 1ps

module ssrch_cfg #(
    parameter int MAX_NEEDLE = 15
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ssrch_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ssrch_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ssrch_pkg::needle_cfg_t             needle_cfg
);

    logic [ssrch_pkg::CFG_DATA_W-1:0] needle_low_reg;
    logic [ssrch_pkg::HIGH_W-1:0]     needle_high_reg;
    logic [ssrch_pkg::LEN_W-1:0]      needle_len_reg;
    logic [ssrch_pkg::LEN_W-1:0]      len_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg  <= '0;
            needle_high_reg <= '0;
            needle_len_reg  <= ssrch_pkg::LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssrch_pkg::REG_NEEDLE_LOW:
                begin
                    needle_low_reg <= cfg_data;
                end
                ssrch_pkg::REG_NEEDLE_HIGH:
                begin
                    needle_high_reg <= cfg_data[ssrch_pkg::HIGH_W-1:0];
                end
                ssrch_pkg::REG_NEEDLE_LEN:
                begin
                    needle_len_reg <= cfg_data[ssrch_pkg::LEN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // zero length acts as one, anything above the window depth as the depth
    always_comb
    begin
        len_eff = needle_len_reg;
        if (needle_len_reg == '0)
        begin
            len_eff = ssrch_pkg::LEN_W'(1);
        end
        else if ({1'b0, needle_len_reg} > (ssrch_pkg::LEN_W + 1)'(MAX_NEEDLE))
        begin
            len_eff = ssrch_pkg::LEN_W'(MAX_NEEDLE);
        end
    end

    assign needle_cfg.needle = {needle_high_reg, needle_low_reg};
    assign needle_cfg.len    = len_eff;

endmodule

// ----- rtl/core/ssrch_match.sv -----
`timescale 1ns / 1ps

module ssrch_match #(
    parameter int MAX_NEEDLE = 15
) (
    input  logic [MAX_NEEDLE-1:0][7:0]  window,
    input  ssrch_pkg::needle_cfg_t      needle_cfg,
    output logic                        hit
);

    logic [MAX_NEEDLE-1:0]         lane_ok;
    logic [ssrch_pkg::LEN_W-1:0]   nidx [MAX_NEEDLE];

    // window entry j (newest first) lines up with needle byte len-1-j
    always_comb
    begin
        for (int j = 0; j < MAX_NEEDLE; j++)
        begin
            nidx[j] = ssrch_pkg::LEN_W'(needle_cfg.len - ssrch_pkg::LEN_W'(1)
                                        - ssrch_pkg::LEN_W'(j));
            if ((ssrch_pkg::LEN_W + 5)'(j) < (ssrch_pkg::LEN_W + 5)'(needle_cfg.len))
            begin
                lane_ok[j] = (window[j] == needle_cfg.needle[nidx[j]]);
            end
            else
            begin
                lane_ok[j] = 1'b1;
            end
        end
    end

    assign hit = &lane_ok;

endmodule

// ----- rtl/core/short_needle_substring_search_core.sv -----
`timescale 1ns / 1ps

// first-match search for a 1 to 15 byte needle in a byte stream, one byte per beat.
// a text beat is taken every cycle unless a finished result sits in the output
// register while result_stall is high; the result of a beat shows on the result
// port in the cycle after the beat is taken. each string yields one result beat:
// found with the start offset on the byte where the first full match ends, or
// not found on the byte marked is_last. offsets past the position range saturate and
// set overflow. the user writes needle registers over cfg only while idle (unenforced).
module short_needle_substring_search_core #(
    parameter int MAX_NEEDLE    = 15,
    parameter int POSITION_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [ssrch_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ssrch_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                    text_valid,
    output logic                                    text_stall,
    input  logic [7:0]                              text_byte,
    input  logic                                    is_last,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic                                    found,
    output logic [ssrch_pkg::OFFSET_BITS-1:0]       match_offset,
    output logic                                    overflow
);

    localparam int COUNT_W = POSITION_BITS + 1;
    localparam int WIDE_W  = COUNT_W > ssrch_pkg::OFFSET_BITS ? COUNT_W
                                                               : ssrch_pkg::OFFSET_BITS;
    localparam logic [63:0] CAP_64   = (64'd1 << POSITION_BITS) + 64'(MAX_NEEDLE);
    localparam logic [63:0] LIMIT_64 = POSITION_BITS < ssrch_pkg::OFFSET_BITS
                                       ? ((64'd1 << POSITION_BITS) - 64'd1)
                                       : ((64'd1 << ssrch_pkg::OFFSET_BITS) - 64'd1);
    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP_64);
    localparam logic [COUNT_W-1:0] OFF_LIMIT = COUNT_W'(LIMIT_64);

    ssrch_pkg::needle_cfg_t        needle_cfg;

    logic [MAX_NEEDLE-1:0][7:0]    window_reg;
    logic [MAX_NEEDLE-1:0][7:0]    window_next;
    logic [MAX_NEEDLE-1:0][7:0]    shift_win;
    logic [COUNT_W-1:0]            count_reg;
    logic [COUNT_W-1:0]            count_next;
    logic [COUNT_W-1:0]            count_inc;
    logic                          reported_reg;
    logic                          reported_next;

    logic                          accept;
    logic                          lane_hit;
    logic                          hit;
    logic                          emit;
    logic [COUNT_W-1:0]            off;
    logic [WIDE_W-1:0]             off_wide;
    logic                          off_ovf;

    logic                          result_valid_reg;
    logic                          result_valid_next;
    logic                          found_reg;
    logic [ssrch_pkg::OFFSET_BITS-1:0] offset_reg;
    logic                          overflow_reg;

    ssrch_cfg #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .needle_cfg (needle_cfg)
    );

    ssrch_match #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_match (
        .window     (shift_win),
        .needle_cfg (needle_cfg),
        .hit        (lane_hit)
    );

    assign text_stall = result_valid_reg & result_stall;
    assign accept     = text_valid & ~text_stall;

    // entry 0 holds the newest byte
    always_comb
    begin
        shift_win[0] = text_byte;
        for (int i = 1; i < MAX_NEEDLE; i++)
        begin
            shift_win[i] = window_reg[i-1];
        end
    end

    assign count_inc = (count_reg < COUNT_CAP) ? count_reg + COUNT_W'(1) : count_reg;

    assign hit  = ~reported_reg & (count_inc >= COUNT_W'(needle_cfg.len)) & lane_hit;
    assign emit = hit | (is_last & ~reported_reg);

    assign off      = count_inc - COUNT_W'(needle_cfg.len);
    assign off_ovf  = off > OFF_LIMIT;
    assign off_wide = off_ovf ? WIDE_W'(OFF_LIMIT) : WIDE_W'(off);

    // the last byte of a string puts the stream state back to reset
    always_comb
    begin
        window_next   = window_reg;
        count_next    = count_reg;
        reported_next = reported_reg;
        if (accept)
        begin
            if (is_last)
            begin
                window_next   = '0;
                count_next    = '0;
                reported_next = 1'b0;
            end
            else
            begin
                window_next   = shift_win;
                count_next    = count_inc;
                reported_next = reported_reg | hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            count_reg    <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            window_reg   <= window_next;
            count_reg    <= count_next;
            reported_reg <= reported_next;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg & result_stall;
        if (accept && emit)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            found_reg    <= hit;
            offset_reg   <= hit ? off_wide[ssrch_pkg::OFFSET_BITS-1:0] : '0;
            overflow_reg <= hit & off_ovf;
        end
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;
    assign overflow     = overflow_reg;

endmodule
